FILE: design/asrm_pkg.sv
// ----------------------------------------------------------------------------
// asrm_pkg
// Shared constants, types and the arctangent table of the sector range merge.
// ----------------------------------------------------------------------------
package asrm_pkg;

  // Default configuration and fixed field widths.
  localparam int unsigned MAX_CLUSTERS_DEF = 32;
  localparam int unsigned ANGLE_BITS_DEF   = 16;
  localparam int unsigned MAX_RESULTS      = 32;
  localparam int unsigned CORDIC_STEPS     = 28;
  localparam int unsigned SECTOR_W         = 17;
  localparam int unsigned COORD_W          = 32;

  // Register indexes of the configuration port.
  localparam logic REG_BASE_X = 1'b0;
  localparam logic REG_BASE_Y = 1'b1;

  // Control beat from the point sequencer to the range table.
  typedef struct packed {
    logic push;   // store the closed cluster's range
    logic frame;  // frame closed: sort, merge and emit
  } asrm_ctrl_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // CORDIC sequencer states.
  typedef enum logic [3:0] {
    CD_IDLE = 4'b0001,
    CD_NORM = 4'b0010,
    CD_ITER = 4'b0100,
    CD_DONE = 4'b1000
  } cd_state_e;

  // Point sequencer states.
  typedef enum logic [2:0] {
    TS_IDLE   = 3'b001,
    TS_CORDIC = 3'b010,
    TS_CLOSE  = 3'b100
  } top_state_e;

  // Range table states.
  typedef enum logic [10:0] {
    RT_IDLE   = 11'b00000000001,
    RT_PREP   = 11'b00000000010,
    RT_S_RDI  = 11'b00000000100,
    RT_S_LDI  = 11'b00000001000,
    RT_S_RDJ  = 11'b00000010000,
    RT_S_CMP  = 11'b00000100000,
    RT_S_WRI  = 11'b00001000000,
    RT_M_RD   = 11'b00010000000,
    RT_M_CHK  = 11'b00100000000,
    RT_M_EMIT = 11'b01000000000,
    RT_M_LAST = 11'b10000000000
  } rt_state_e;

endpackage

FILE: design/angular_sector_range_merge.sv
// ----------------------------------------------------------------------------
// angular_sector_range_merge
// Polar angle ranges of point clusters, sorted and merged into sectors.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat contents
// s_axis    in         point_x, point_y; tuser point_present, cluster_end;
//                      tlast frame_end
// m_axis    out        sector_start, sector_end; tlast last_sector;
//                      tuser cluster_overflow
// apb       in/out     base_x at 0x0, base_y at 0x4
//
// A point off the axes passes through the normalisation steps of the iterative
// CORDIC, 28 rotations, and the hand-over and close; other beats go straight
// to the close.
// A frame end adds the exchange sort over the range memory and two merge
// passes over the n stored ranges.
// Reset clears all control state; the range memory needs no clearing pass.
// A stalled m_axis holds the merge walk; s_axis is not ready meanwhile.
// ----------------------------------------------------------------------------
module angular_sector_range_merge #(
  parameter int unsigned MAX_CLUSTERS = asrm_pkg::MAX_CLUSTERS_DEF,
  parameter int unsigned ANGLE_BITS   = asrm_pkg::ANGLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input points
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // point_x[31:0], point_y[63:32]
  input  logic [1:0]  s_axis_tuser,  // point_present[0], cluster_end[1]
  input  logic        s_axis_tlast,
  // Merged sectors
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // sector_start[16:0], sector_end[33:17], zeros
  output logic        m_axis_tuser,  // cluster_overflow[0]
  output logic        m_axis_tlast,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = ANGLE_BITS + 1;
  localparam logic [AW-1:0] FULL = AW'(1) << ANGLE_BITS;
  localparam logic [AW-1:0] HALF = AW'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  asrm_pkg::top_state_e  state_q, state_d;
  asrm_pkg::asrm_ctrl_t  ctrl;
  logic [31:0]           base_x_q, base_y_q;
  logic                  in_acc, cfg_wr;
  logic signed [32:0]    dx, dy;
  logic [32:0]           mag_x, mag_y;
  logic                  need_cordic, rt_busy, cd_done;
  logic [ANGLE_BITS-1:0] cd_angle, t_q, t_d;
  logic                  dx_pos_q, dx_neg_q, dy_pos_q, dy_neg_q, coinc_q;
  logic                  present_q, cend_q, fend_q;
  logic [AW-1:0]         min_q, min_d, max_q, max_d, angle, new_min, new_max;
  logic [AW-1:0]         sec_s, sec_e;
  logic                  sec_l, sec_o;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == asrm_pkg::REG_BASE_Y) ? base_y_q : base_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q <= '0;
      base_y_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == asrm_pkg::REG_BASE_X) begin
        base_x_q <= pwdata;
      end else begin
        base_y_q <= pwdata;
      end
    end
  end

  // Offsets from the base point and their magnitudes.
  always_comb begin
    dx    = $signed({s_axis_tdata[31], s_axis_tdata[31:0]}) - $signed({base_x_q[31], base_x_q});
    dy    = $signed({s_axis_tdata[63], s_axis_tdata[63:32]}) - $signed({base_y_q[31], base_y_q});
    mag_x = dx[32] ? 33'(-dx) : 33'(dx);
    mag_y = dy[32] ? 33'(-dy) : 33'(dy);
    need_cordic = s_axis_tuser[0] && (dx != '0) && (dy != '0);
  end

  assign s_axis_tready = (state_q == asrm_pkg::TS_IDLE) && !rt_busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  asrm_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && need_cordic),
    .mag_x_i (mag_x),
    .mag_y_i (mag_y),
    .done_o  (cd_done),
    .angle_o (cd_angle)
  );

  // Quadrant fold and running extremes of the open cluster.
  always_comb begin
    if (coinc_q) begin
      angle = '0;
    end else if (dx_pos_q && dy_pos_q) begin
      angle = AW'(t_q);
    end else if (dx_neg_q && dy_pos_q) begin
      angle = HALF - AW'(t_q);
    end else if (dx_neg_q && dy_neg_q) begin
      angle = HALF + AW'(t_q);
    end else begin
      angle = FULL - AW'(t_q);
    end
    new_min = min_q;
    new_max = max_q;
    if (present_q) begin
      if (angle < min_q) new_min = angle;
      if (angle > max_q) new_max = angle;
    end
  end

  // Point sequencer.
  always_comb begin
    state_d    = state_q;
    t_d        = t_q;
    min_d      = min_q;
    max_d      = max_q;
    ctrl.push  = 1'b0;
    ctrl.frame = 1'b0;
    unique case (state_q)
      asrm_pkg::TS_IDLE: begin
        if (in_acc) begin
          t_d     = (dy == '0) ? '0 : QUARTER;
          state_d = need_cordic ? asrm_pkg::TS_CORDIC : asrm_pkg::TS_CLOSE;
        end
      end
      asrm_pkg::TS_CORDIC: begin
        if (cd_done) begin
          t_d     = cd_angle;
          state_d = asrm_pkg::TS_CLOSE;
        end
      end
      asrm_pkg::TS_CLOSE: begin
        min_d = new_min;
        max_d = new_max;
        if (cend_q || fend_q) begin
          ctrl.push = 1'b1;
          min_d     = FULL;
          max_d     = '0;
        end
        ctrl.frame = fend_q;
        state_d    = asrm_pkg::TS_IDLE;
      end
      default: state_d = asrm_pkg::TS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asrm_pkg::TS_IDLE;
      min_q   <= FULL;
      max_q   <= '0;
    end else begin
      state_q <= state_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

  // Beat fields held for the fold.
  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    if (in_acc) begin
      dx_pos_q  <= !dx[32] && (dx != '0);
      dx_neg_q  <= dx[32];
      dy_pos_q  <= !dy[32] && (dy != '0);
      dy_neg_q  <= dy[32];
      coinc_q   <= (dx == '0) && (dy == '0);
      present_q <= s_axis_tuser[0];
      cend_q    <= s_axis_tuser[1];
      fend_q    <= s_axis_tlast;
    end
  end

  asrm_range_table #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .ANGLE_W      (AW)
  ) u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .range_start_i (new_min),
    .range_end_i   (new_max),
    .busy_o        (rt_busy),
    .m_ready_i     (m_axis_tready),
    .m_valid_o     (m_axis_tvalid),
    .sec_start_o   (sec_s),
    .sec_end_o     (sec_e),
    .last_o        (sec_l),
    .ovf_o         (sec_o)
  );

  // Output beat packing.
  assign m_axis_tdata = {6'd0, asrm_pkg::SECTOR_W'(sec_e), asrm_pkg::SECTOR_W'(sec_s)};
  assign m_axis_tlast = sec_l;
  assign m_axis_tuser = sec_o;

endmodule

FILE: design/asrm_cordic.sv
// ----------------------------------------------------------------------------
// asrm_cordic
// Iterative vectoring CORDIC: first-quadrant angle of two positive magnitudes.
// ----------------------------------------------------------------------------
module asrm_cordic #(
  parameter int unsigned ANGLE_BITS = asrm_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [32:0]           mag_x_i,
  input  logic [32:0]           mag_y_i,
  output logic                  done_o,
  output logic [ANGLE_BITS-1:0] angle_o
);

  localparam int unsigned XW = 44;
  localparam int unsigned ZW = 34;
  localparam logic [XW-1:0] LIM32 = XW'(1) << 32;
  localparam logic [XW-1:0] LIM40 = XW'(1) << 40;
  localparam logic [ZW-1:0] ZMAX  = ZW'(1) << 30;

  asrm_pkg::cd_state_e state_q, state_d;
  logic [XW-1:0]         x_q, x_d, y_q, y_d;
  logic [ZW-1:0]         z_q, z_d;
  logic [4:0]            i_q, i_d;
  logic [ANGLE_BITS-1:0] angle_q, angle_d;
  logic [XW-1:0]         mx;
  logic signed [XW-1:0]  sx, sy;
  logic [ZW-1:0]         atan_z;
  logic [30:0]           z_clamp;
  logic [31:0]           z_round;

  // Shared datapath: larger magnitude, shifted terms, table entry and rounded angle.
  always_comb begin
    mx      = (x_q > y_q) ? x_q : y_q;
    sx      = $signed(x_q) >>> i_q;
    sy      = $signed(y_q) >>> i_q;
    atan_z  = ZW'(asrm_pkg::atan_entry(i_q));
    if (z_q[ZW-1]) begin
      z_clamp = '0;
    end else if ($signed(z_q) > $signed(ZMAX)) begin
      z_clamp = 31'(ZMAX);
    end else begin
      z_clamp = z_q[30:0];
    end
    z_round = 32'(z_clamp) + (32'd1 << (31 - ANGLE_BITS));
  end

  // Sequencer: normalise, then one rotation per cycle.
  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    i_d     = i_q;
    angle_d = angle_q;
    unique case (state_q)
      asrm_pkg::CD_IDLE: begin
        if (start_i) begin
          x_d     = XW'(mag_x_i);
          y_d     = XW'(mag_y_i);
          z_d     = '0;
          i_d     = '0;
          state_d = asrm_pkg::CD_NORM;
        end
      end
      asrm_pkg::CD_NORM: begin
        if (mx < LIM32) begin
          x_d = x_q << 8;
          y_d = y_q << 8;
        end else if (mx < LIM40) begin
          x_d = x_q << 1;
          y_d = y_q << 1;
        end else begin
          state_d = asrm_pkg::CD_ITER;
        end
      end
      asrm_pkg::CD_ITER: begin
        if (!y_q[XW-1]) begin
          x_d = XW'($signed(x_q) + sy);
          y_d = XW'($signed(y_q) - sx);
          z_d = z_q + atan_z;
        end else begin
          x_d = XW'($signed(x_q) - sy);
          y_d = XW'($signed(y_q) + sx);
          z_d = z_q - atan_z;
        end
        i_d = i_q + 5'd1;
        if (i_q == 5'(asrm_pkg::CORDIC_STEPS - 1)) begin
          state_d = asrm_pkg::CD_DONE;
        end
      end
      asrm_pkg::CD_DONE: begin
        angle_d = z_round[31 -: ANGLE_BITS];
        state_d = asrm_pkg::CD_IDLE;
      end
      default: state_d = asrm_pkg::CD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asrm_pkg::CD_IDLE;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == asrm_pkg::CD_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    i_q     <= i_d;
    angle_q <= angle_d;
  end

  assign angle_o = angle_q;

endmodule

FILE: design/asrm_range_table.sv
// ----------------------------------------------------------------------------
// asrm_range_table
// Range memory with exchange sort, two-pass merge and the result register.
// ----------------------------------------------------------------------------
module asrm_range_table #(
  parameter int unsigned MAX_CLUSTERS = asrm_pkg::MAX_CLUSTERS_DEF,
  parameter int unsigned ANGLE_W      = asrm_pkg::ANGLE_BITS_DEF + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  asrm_pkg::asrm_ctrl_t ctrl_i,
  input  logic [ANGLE_W-1:0]   range_start_i,
  input  logic [ANGLE_W-1:0]   range_end_i,
  output logic                 busy_o,
  input  logic                 m_ready_i,
  output logic                 m_valid_o,
  output logic [ANGLE_W-1:0]   sec_start_o,
  output logic [ANGLE_W-1:0]   sec_end_o,
  output logic                 last_o,
  output logic                 ovf_o
);

  localparam int unsigned CW  = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned IW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned RW  = $clog2(asrm_pkg::MAX_RESULTS + 1);
  localparam int unsigned TW  = (CW > RW) ? CW : RW;
  localparam int unsigned EW  = 2 * ANGLE_W;
  localparam logic [TW-1:0] MR = TW'(asrm_pkg::MAX_RESULTS);

  asrm_pkg::rt_state_e state_q, state_d;
  logic [EW-1:0]      mem [MAX_CLUSTERS];
  logic [EW-1:0]      rd_q;
  logic               we;
  logic [IW-1:0]      waddr, raddr;
  logic [EW-1:0]      wdata;
  logic [CW-1:0]      count_q, count_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic               ov_q, ov_d, pass_q, pass_d;
  logic [EW-1:0]      reg_i_q, reg_i_d, nxt_q, nxt_d;
  logic [ANGLE_W-1:0] cur_s_q, cur_s_d, cur_e_q, cur_e_d;
  logic [TW-1:0]      tot_q, tot_d, cnt_q, cnt_d, lim;
  logic               out_v_q, out_v_d, out_l_q, out_l_d, out_o_q, out_o_d;
  logic [ANGLE_W-1:0] out_s_q, out_s_d, out_e_q, out_e_d;
  logic               slot_free, emit_go, emit_load;
  logic [ANGLE_W-1:0] rd_s, rd_e, ri_s;

  assign rd_s      = rd_q[EW-1 -: ANGLE_W];
  assign rd_e      = rd_q[ANGLE_W-1:0];
  assign ri_s      = reg_i_q[EW-1 -: ANGLE_W];
  assign slot_free = !out_v_q || m_ready_i;
  assign lim       = (tot_q > MR) ? MR : tot_q;

  // Emission of the current sector: counted in the first pass, sent in the second up to MAX_RESULTS.
  always_comb begin
    emit_load = pass_q && (cnt_q < MR);
    emit_go   = !emit_load || slot_free;
  end

  // Sequencer for storing, sorting and merging.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ov_d    = ov_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    pass_d  = pass_q;
    reg_i_d = reg_i_q;
    nxt_d   = nxt_q;
    cur_s_d = cur_s_q;
    cur_e_d = cur_e_q;
    tot_d   = tot_q;
    cnt_d   = cnt_q;
    out_v_d = out_v_q && !m_ready_i;
    out_s_d = out_s_q;
    out_e_d = out_e_q;
    out_l_d = out_l_q;
    out_o_d = out_o_q;
    we      = 1'b0;
    waddr   = count_q[IW-1:0];
    wdata   = {range_start_i, range_end_i};
    raddr   = i_q[IW-1:0];
    unique case (state_q) inside
      asrm_pkg::RT_IDLE: begin
        if (ctrl_i.push) begin
          if (count_q < CW'(MAX_CLUSTERS)) begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
          end else begin
            ov_d = 1'b1;
          end
        end
        if (ctrl_i.frame) begin
          state_d = asrm_pkg::RT_PREP;
        end
      end
      asrm_pkg::RT_PREP: begin
        i_d    = '0;
        k_d    = '0;
        pass_d = 1'b0;
        tot_d  = '0;
        cnt_d  = '0;
        if (count_q == '0) begin
          ov_d    = 1'b0;
          state_d = asrm_pkg::RT_IDLE;
        end else if (count_q < CW'(2)) begin
          state_d = asrm_pkg::RT_M_RD;
        end else begin
          state_d = asrm_pkg::RT_S_RDI;
        end
      end
      asrm_pkg::RT_S_RDI: begin
        raddr   = i_q[IW-1:0];
        state_d = asrm_pkg::RT_S_LDI;
      end
      asrm_pkg::RT_S_LDI: begin
        reg_i_d = rd_q;
        j_d     = i_q + CW'(1);
        state_d = asrm_pkg::RT_S_RDJ;
      end
      asrm_pkg::RT_S_RDJ: begin
        raddr   = j_q[IW-1:0];
        state_d = asrm_pkg::RT_S_CMP;
      end
      asrm_pkg::RT_S_CMP: begin
        if (ri_s > rd_s) begin
          we      = 1'b1;
          waddr   = j_q[IW-1:0];
          wdata   = reg_i_q;
          reg_i_d = rd_q;
        end
        j_d = j_q + CW'(1);
        if (j_q + CW'(1) < count_q) begin
          state_d = asrm_pkg::RT_S_RDJ;
        end else begin
          state_d = asrm_pkg::RT_S_WRI;
        end
      end
      asrm_pkg::RT_S_WRI: begin
        we    = 1'b1;
        waddr = i_q[IW-1:0];
        wdata = reg_i_q;
        if (i_q + CW'(2) < count_q) begin
          i_d     = i_q + CW'(1);
          state_d = asrm_pkg::RT_S_RDI;
        end else begin
          k_d     = '0;
          state_d = asrm_pkg::RT_M_RD;
        end
      end
      asrm_pkg::RT_M_RD: begin
        raddr   = k_q[IW-1:0];
        state_d = asrm_pkg::RT_M_CHK;
      end
      asrm_pkg::RT_M_CHK: begin
        if (k_q == '0 || cur_e_q > rd_s) begin
          if (k_q == '0) begin
            cur_s_d = rd_s;
            cur_e_d = rd_e;
          end else if (rd_e > cur_e_q) begin
            cur_e_d = rd_e;
          end
          k_d = k_q + CW'(1);
          if (k_q + CW'(1) < count_q) begin
            state_d = asrm_pkg::RT_M_RD;
          end else begin
            state_d = asrm_pkg::RT_M_LAST;
          end
        end else begin
          nxt_d   = rd_q;
          state_d = asrm_pkg::RT_M_EMIT;
        end
      end
      asrm_pkg::RT_M_EMIT, asrm_pkg::RT_M_LAST: begin
        if (emit_go) begin
          if (!pass_q) begin
            tot_d = tot_q + TW'(1);
          end else if (emit_load) begin
            out_v_d = 1'b1;
            out_s_d = cur_s_q;
            out_e_d = cur_e_q;
            out_l_d = (cnt_q == lim - TW'(1));
            out_o_d = ov_q || (tot_q > MR);
            cnt_d   = cnt_q + TW'(1);
          end
          if (state_q == asrm_pkg::RT_M_EMIT) begin
            cur_s_d = nxt_q[EW-1 -: ANGLE_W];
            cur_e_d = nxt_q[ANGLE_W-1:0];
            k_d     = k_q + CW'(1);
            if (k_q + CW'(1) < count_q) begin
              state_d = asrm_pkg::RT_M_RD;
            end else begin
              state_d = asrm_pkg::RT_M_LAST;
            end
          end else if (!pass_q) begin
            pass_d  = 1'b1;
            k_d     = '0;
            state_d = asrm_pkg::RT_M_RD;
          end else begin
            count_d = '0;
            ov_d    = 1'b0;
            state_d = asrm_pkg::RT_IDLE;
          end
        end
      end
      default: state_d = asrm_pkg::RT_IDLE;
    endcase
  end

  // Range memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asrm_pkg::RT_IDLE;
      count_q <= '0;
      ov_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    k_q     <= k_d;
    pass_q  <= pass_d;
    reg_i_q <= reg_i_d;
    nxt_q   <= nxt_d;
    cur_s_q <= cur_s_d;
    cur_e_q <= cur_e_d;
    tot_q   <= tot_d;
    cnt_q   <= cnt_d;
    out_s_q <= out_s_d;
    out_e_q <= out_e_d;
    out_l_q <= out_l_d;
    out_o_q <= out_o_d;
  end

  assign busy_o      = (state_q != asrm_pkg::RT_IDLE);
  assign m_valid_o   = out_v_q;
  assign sec_start_o = out_s_q;
  assign sec_end_o   = out_e_q;
  assign last_o      = out_l_q;
  assign ovf_o       = out_o_q;

endmodule
